// File: src/b64_pkg.sv
// Shared types and constants for the strict Base64 stream decoder.
// Holds the character-to-sextet lookup and the decoded group record.
// Depends on nothing; used by every module of the decoder.
package b64_pkg;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  localparam logic [5:0] SEXTET_LOWER_BASE = 6'h1A;
  localparam logic [5:0] SEXTET_DIGIT_BASE = 6'h34;
  localparam logic [5:0] SEXTET_PLUS       = 6'd62;
  localparam logic [5:0] SEXTET_SLASH      = 6'd63;

  localparam logic [3:0] LEFTOVER_MASK_TWO_PAD = 4'hF;
  localparam logic [1:0] LEFTOVER_MASK_ONE_PAD = 2'h3;

  localparam logic [1:0] QUAD_POS_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_POS_SECOND = 2'd1;
  localparam logic [1:0] QUAD_POS_THIRD  = 2'd2;
  localparam logic [1:0] QUAD_POS_FOURTH = 2'd3;

  typedef struct packed {
    logic        ok;
    logic [5:0]  value;
  } sextet_t;

  // One group of results caused by a single input character.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        eom;
    logic        err;
  } group_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.ok    = 1'b1;
    s.value = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      s.value = 6'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      s.value = SEXTET_LOWER_BASE + 6'(c - CHAR_LOWER_A);
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      s.value = SEXTET_DIGIT_BASE + 6'(c - CHAR_DIGIT_0);
    end else if (c == CHAR_PLUS) begin
      s.value = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      s.value = SEXTET_SLASH;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

// File: src/base64_strict_stream_decoder.sv
// Top level of the strict Base64 stream decoder.
// Instantiates b64_quad_decoder and b64_result_serializer; uses b64_pkg.
//
// The input channel takes one ASCII character per transaction, with in_is_last
// on the final character of a message. Every fourth character completes a quad
// and yields up to three byte transactions on the output channel, one per cycle
// while out_ready is high. The final transaction of a message carries
// out_end_of_message, and out_decode_error tells the consumer to discard every
// byte of that message. A message with an error, or whose last quad yields no
// byte, ends with a single transaction that has out_byte_valid low.
// Throughput is one character per cycle while in_ready is high; the output
// stage drains one byte per cycle while out_ready is high, which a quad of
// four characters never outruns. A result passes the decode register, then the
// output register. One result group can wait while the output is stalled, so
// characters keep being accepted until a second group is ready; then in_ready
// drops until the receiver takes results. cfg_wr_data sets the byte limit per
// message. Reset clears the message state and sets the limit to 65534.
module base64_strict_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_code_char,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic        out_byte_valid,
  output logic        out_end_of_message,
  output logic        out_decode_error
);

  logic            grp_valid;
  logic            grp_take;
  b64_pkg::group_t grp;

  b64_quad_decoder u_dec (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_char (in_code_char),
    .in_is_last   (in_is_last),
    .grp_valid    (grp_valid),
    .grp          (grp),
    .grp_take     (grp_take)
  );

  b64_result_serializer u_ser (
    .clk                (clk),
    .rst_n              (rst_n),
    .grp_valid          (grp_valid),
    .grp                (grp),
    .grp_take           (grp_take),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data_byte      (out_data_byte),
    .out_byte_valid     (out_byte_valid),
    .out_end_of_message (out_end_of_message),
    .out_decode_error   (out_decode_error)
  );

  // An error is only reported on an end transaction that carries no byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decode_error |-> out_end_of_message && !out_byte_valid)
    else $error("decode error outside an empty end transaction");

  // Every result either carries a byte or closes a message.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_valid || out_end_of_message)
    else $error("empty result that does not end a message");

  // Input stalls only while a decoded group is waiting for the output stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> grp_valid && out_valid && !grp_take)
    else $error("input stalled without a waiting group");

  // A group is handed over only when the output stage is free or finishing.
  assert property (@(posedge clk) disable iff (!rst_n)
    grp_take && out_valid |-> out_ready && (out_end_of_message || $past(grp_take) == 1'b0
      || out_byte_valid))
    else $error("group handed over while output stage is busy");

endmodule

// File: src/b64_quad_decoder.sv
// Per-character decode, quad assembly, validation and byte limiting.
// Holds the message state and one pending result group for the serializer.
// Depends on b64_pkg.
module b64_quad_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_code_char,
  input  logic               in_is_last,
  output logic               grp_valid,
  output b64_pkg::group_t    grp,
  input  logic               grp_take
);

  logic [15:0]      limit_r;
  logic [1:0]       qpos_r, qpos_nxt;
  logic [17:0]      acc_r, acc_nxt;
  logic             pit_r, pit_nxt;
  logic             err_seen_r, err_seen_nxt;
  logic [15:0]      emitted_r, emitted_nxt;
  logic             grp_valid_r, grp_valid_nxt;
  b64_pkg::group_t  grp_r, grp_nxt;

  b64_pkg::sextet_t sx;
  logic             is_pad;
  logic             err;
  logic [1:0]       count;
  logic [1:0]       nbytes;
  logic [15:0]      remaining;
  logic             accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !grp_valid_r || grp_take;
  assign grp_valid = grp_valid_r;
  assign grp       = grp_r;

  always_comb begin
    sx           = b64_pkg::sextet_of(in_code_char);
    is_pad       = (in_code_char == b64_pkg::CHAR_PAD);
    err          = 1'b0;
    count        = 2'd0;
    nbytes       = 2'd0;
    remaining    = limit_r - emitted_r;
    qpos_nxt     = qpos_r;
    acc_nxt      = acc_r;
    pit_nxt      = pit_r;
    err_seen_nxt = err_seen_r;
    emitted_nxt  = emitted_r;
    grp_nxt      = grp_r;

    if (grp_take) begin
      grp_valid_nxt = 1'b0;
    end else begin
      grp_valid_nxt = grp_valid_r;
    end

    if (accept) begin
      unique case (qpos_r)
        b64_pkg::QUAD_POS_FIRST: begin
          err     = !sx.ok;
          pit_nxt = 1'b0;
          acc_nxt = {12'b0, sx.value};
        end
        b64_pkg::QUAD_POS_SECOND: begin
          err     = !sx.ok;
          acc_nxt = {acc_r[11:0], sx.value};
        end
        b64_pkg::QUAD_POS_THIRD: begin
          if (is_pad) begin
            pit_nxt = 1'b1;
            err     = (acc_r[3:0] & b64_pkg::LEFTOVER_MASK_TWO_PAD) != 4'b0;
          end else begin
            err = !sx.ok;
          end
          acc_nxt = {acc_r[11:0], sx.value};
        end
        b64_pkg::QUAD_POS_FOURTH: begin
          if (pit_r) begin
            err = !is_pad;
          end else if (is_pad) begin
            err = (acc_r[1:0] & b64_pkg::LEFTOVER_MASK_ONE_PAD) != 2'b0;
          end else begin
            err = !sx.ok;
          end
          if ((pit_r || is_pad) && !in_is_last) begin
            err = 1'b1;
          end
          count = pit_r ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
          if (!err && !err_seen_r && emitted_r < limit_r) begin
            if (remaining >= 16'(count)) begin
              nbytes = count;
            end else begin
              nbytes = remaining[1:0];
            end
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase

      if (in_is_last && qpos_r != b64_pkg::QUAD_POS_FOURTH) begin
        err = 1'b1;
      end
      err_seen_nxt = err_seen_r || err;
      qpos_nxt     = qpos_r + 2'd1;
      emitted_nxt  = emitted_r + 16'(nbytes);

      grp_nxt.word   = {acc_r, sx.value};
      grp_nxt.nbytes = nbytes;
      grp_nxt.eom    = in_is_last;
      grp_nxt.err    = in_is_last && err_seen_nxt;
      if (nbytes != 2'd0 || in_is_last) begin
        grp_valid_nxt = 1'b1;
      end

      if (in_is_last) begin
        qpos_nxt     = '0;
        acc_nxt      = '0;
        pit_nxt      = 1'b0;
        err_seen_nxt = 1'b0;
        emitted_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= 16'd65534;
      qpos_r      <= '0;
      acc_r       <= '0;
      pit_r       <= 1'b0;
      err_seen_r  <= 1'b0;
      emitted_r   <= '0;
      grp_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      qpos_r      <= qpos_nxt;
      acc_r       <= acc_nxt;
      pit_r       <= pit_nxt;
      err_seen_r  <= err_seen_nxt;
      emitted_r   <= emitted_nxt;
      grp_valid_r <= grp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

endmodule

// File: src/b64_result_serializer.sv
// Output stage that takes one result group from the decoder and sends it as
// byte transactions, one registered result per cycle while out_ready is high.
// Depends on b64_pkg.
module b64_result_serializer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               grp_valid,
  input  b64_pkg::group_t    grp,
  output logic               grp_take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_data_byte,
  output logic               out_byte_valid,
  output logic               out_end_of_message,
  output logic               out_decode_error
);

  logic        head_valid_r, head_valid_nxt;
  logic [23:0] word_r, word_nxt;
  logic [1:0]  left_r, left_nxt;
  logic        nob_r, nob_nxt;
  logic        eom_r, eom_nxt;
  logic        err_r, err_nxt;
  logic        last_one;
  logic        emit;

  assign last_one = (left_r == 2'd1);
  assign emit     = head_valid_r && out_ready;
  assign grp_take = grp_valid && (!head_valid_r || (emit && last_one));

  assign out_valid          = head_valid_r;
  assign out_data_byte      = nob_r ? 8'h00 : word_r[23:16];
  assign out_byte_valid     = !nob_r;
  assign out_end_of_message = eom_r && last_one;
  assign out_decode_error   = err_r && last_one;

  always_comb begin
    head_valid_nxt = head_valid_r;
    word_nxt       = word_r;
    left_nxt       = left_r;
    nob_nxt        = nob_r;
    eom_nxt        = eom_r;
    err_nxt        = err_r;
    if (emit) begin
      word_nxt = {word_r[15:0], 8'h00};
      left_nxt = left_r - 2'd1;
      if (last_one) begin
        head_valid_nxt = 1'b0;
      end
    end
    if (grp_take) begin
      head_valid_nxt = 1'b1;
      word_nxt       = grp.word;
      nob_nxt        = (grp.nbytes == 2'd0);
      left_nxt       = (grp.nbytes == 2'd0) ? 2'd1 : grp.nbytes;
      eom_nxt        = grp.eom;
      err_nxt        = grp.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    left_r <= left_nxt;
    nob_r  <= nob_nxt;
    eom_r  <= eom_nxt;
    err_r  <= err_nxt;
  end

endmodule
